### hw/rtl/address_hash_map_defines.svh
// assertion macros shared by the address hash map checkers
`ifndef ADDRESS_HASH_MAP_DEFINES_SVH
`define ADDRESS_HASH_MAP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define AHM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define AHM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ahm_pkg.sv
// shared types, constants and command words of the address hash map
`default_nettype none

package ahm_pkg;

  // default geometry of the table
  localparam int unsigned NUM_BUCKETS_DEF = 256;
  localparam int unsigned CHAIN_DEPTH_DEF = 4;

  // word field widths
  localparam int unsigned KIND_W = 2;
  localparam int unsigned KEY_W  = 48;
  localparam int unsigned VAL_W  = 48;

  // hash arithmetic
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned HALF_W     = HASH_W / 2;
  localparam int unsigned HASH_SHIFT = 16;
  localparam logic [HALF_W-1:0] HASH_MULT = 32'd2654435761;

  // remainder unit folds this many hash bits per cycle
  localparam int unsigned MOD_DIGIT = 8;
  localparam logic [2:0]  HASH_LAST = 3'd6;
  localparam logic [2:0]  MOD_LAST  = 3'(HASH_W / MOD_DIGIT - 1);

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // result status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // hash unit operations
  typedef enum logic [2:0] {
    HOP_NONE   = 3'd0,
    HOP_MUL_LO = 3'd1,
    HOP_MUL_HI = 3'd2,
    HOP_ADD    = 3'd3,
    HOP_FIN    = 3'd4,
    HOP_MOD    = 3'd5
  } hop_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    hop_e hop;
    logic rd;
    logic sweep;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] in_kind;
    logic              sweep_last;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/ahm_in_if.sv
// request channel of the address hash map
`default_nettype none

interface ahm_in_if;
  logic                       valid;
  logic                       ready;
  logic [ahm_pkg::KIND_W-1:0] kind;
  logic [ahm_pkg::KEY_W-1:0]  key;
  logic [ahm_pkg::VAL_W-1:0]  value;

  modport source (output valid, kind, key, value, input ready);
  modport sink (input valid, kind, key, value, output ready);
endinterface

`default_nettype wire

### hw/rtl/ahm_out_if.sv
// result channel of the address hash map
`default_nettype none

interface ahm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [ahm_pkg::VAL_W-1:0] match_value;
  logic                      status;

  modport source (output valid, found, match_value, status, input ready);
  modport sink (input valid, found, match_value, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/address_hash_map.sv
// top level of the address hash map: controller, datapath and bucket ram
// insert/lookup: 7 hash steps, then 8 remainder steps when NUM_BUCKETS is not a
//   power of two, 1 ram read, then 1 commit once the result register is free.
// clear: one bucket row cleared per cycle on the ram port, then the result commit.
// one word in flight; a result waiting in the output register does not block intake.
// after reset the bucket ram is cleared row by row before ready rises.
`default_nettype none

module address_hash_map #(
  parameter int unsigned NUM_BUCKETS = ahm_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned CHAIN_DEPTH = ahm_pkg::CHAIN_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ahm_in_if.sink     in_i,
  ahm_out_if.source  out_o
);

  ahm_pkg::cmd_t cmd;
  ahm_pkg::sts_t sts;

  // control
  ahm_ctrl #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  ahm_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (in_i.kind),
    .key_i         (in_i.key),
    .value_i       (in_i.value),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .found_o       (out_o.found),
    .match_value_o (out_o.match_value),
    .status_o      (out_o.status)
  );

endmodule

`default_nettype wire

### hw/rtl/ahm_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module ahm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/ahm_dp.sv
// datapath: hash unit, remainder unit, bucket ram and result register
`default_nettype none

module ahm_dp #(
  parameter int unsigned NUM_BUCKETS = ahm_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned CHAIN_DEPTH = ahm_pkg::CHAIN_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ahm_pkg::cmd_t              cmd_i,
  output ahm_pkg::sts_t              sts_o,
  input  logic [ahm_pkg::KIND_W-1:0] kind_i,
  input  logic [ahm_pkg::KEY_W-1:0]  key_i,
  input  logic [ahm_pkg::VAL_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       found_o,
  output logic [ahm_pkg::VAL_W-1:0]  match_value_o,
  output logic                       status_o
);

  localparam int unsigned BW      = $clog2(NUM_BUCKETS);
  localparam int unsigned FILL_W  = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned ENTRY_W = ahm_pkg::KEY_W + ahm_pkg::VAL_W;
  localparam int unsigned ROW_W   = FILL_W + CHAIN_DEPTH * ENTRY_W;
  localparam bit          POW2    = (NUM_BUCKETS == (1 << BW));
  localparam logic [BW:0]       NB_EXT    = (BW + 1)'(NUM_BUCKETS);
  localparam logic [BW-1:0]     LAST_BKT  = BW'(NUM_BUCKETS - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(CHAIN_DEPTH);
  localparam int unsigned HW = ahm_pkg::HASH_W;
  localparam int unsigned LW = ahm_pkg::HALF_W;

  // item registers
  logic [ahm_pkg::KIND_W-1:0] kind_q;
  logic [ahm_pkg::KEY_W-1:0]  key_q;
  logic [ahm_pkg::VAL_W-1:0]  value_q;

  // hash unit registers
  logic [HW-1:0] h_q;
  logic [HW-1:0] plo_q;
  logic [LW-1:0] phi_q;
  logic [BW-1:0] rem_q;
  logic [BW-1:0] bucket_q;
  logic [BW-1:0] sweep_q;

  // result register
  logic                      out_valid_q;
  logic                      found_q;
  logic [ahm_pkg::VAL_W-1:0] mval_q;
  logic                      status_q;

  logic [HW-1:0]     mix;
  logic [HW-1:0]     mul_lo;
  logic [LW-1:0]     mul_hi;
  logic [BW-1:0]     rem_next;
  logic [BW-1:0]     rem_r;
  logic [BW:0]       rem_t;
  logic [BW-1:0]     bucket_w;
  logic              sweep_last;
  logic [ROW_W-1:0]  row_rd;
  logic [ROW_W-1:0]  row_new;
  logic [FILL_W-1:0] fill;
  logic              full;
  logic              hit;
  logic [ahm_pkg::VAL_W-1:0] hit_val;
  logic              is_insert;
  logic              is_lookup;
  logic              we;
  logic [BW-1:0]     waddr;
  logic [ROW_W-1:0]  wdata;

  // xor-shift and the two halves of the 64x32 product
  assign mix    = h_q ^ (h_q << ahm_pkg::HASH_SHIFT);
  assign mul_lo = {{LW{1'b0}}, mix[LW-1:0]} * {{LW{1'b0}}, ahm_pkg::HASH_MULT};
  assign mul_hi = mix[HW-1:LW] * ahm_pkg::HASH_MULT;

  // one digit of the remainder, msb first, one compare-subtract per bit
  always_comb begin
    rem_r = rem_q;
    rem_t = '0;
    for (int i = 0; i < ahm_pkg::MOD_DIGIT; i++) begin
      rem_t = {rem_r, h_q[HW-1-i]};
      if (rem_t >= NB_EXT) begin
        rem_t = rem_t - NB_EXT;
      end
      rem_r = rem_t[BW-1:0];
    end
    rem_next = rem_r;
  end

  assign bucket_w = POW2 ? h_q[BW-1:0] : rem_q;

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // hash and remainder sequencing
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      h_q <= HW'(key_i);
    end else begin
      case (cmd_i.hop)
        ahm_pkg::HOP_MUL_LO: plo_q <= mul_lo;
        ahm_pkg::HOP_MUL_HI: phi_q <= mul_hi;
        ahm_pkg::HOP_ADD:    h_q   <= plo_q + {phi_q, {LW{1'b0}}};
        ahm_pkg::HOP_FIN: begin
          h_q   <= mix;
          rem_q <= '0;
        end
        ahm_pkg::HOP_MOD: begin
          h_q   <= h_q << ahm_pkg::MOD_DIGIT;
          rem_q <= rem_next;
        end
        default: ;
      endcase
    end
  end

  // bucket latched with the read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      bucket_q <= bucket_w;
    end
  end

  // clearing sweep address
  assign sweep_last = (sweep_q == LAST_BKT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
    end
  end

  // bucket rows: fill count then the chain slots, slot 0 oldest
  ahm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (bucket_w),
    .rdata_o (row_rd)
  );

  assign fill      = row_rd[FILL_W-1:0];
  assign full      = (fill >= FILL_FULL);
  assign is_insert = (kind_q == ahm_pkg::KIND_INSERT);
  assign is_lookup = (kind_q == ahm_pkg::KIND_LOOKUP);

  // insert: new entry in the first free slot
  always_comb begin
    row_new = row_rd;
    row_new[FILL_W-1:0] = fill + 1'b1;
    for (int s = 0; s < CHAIN_DEPTH; s++) begin
      if (FILL_W'(s) == fill) begin
        row_new[FILL_W + s*ENTRY_W +: ENTRY_W] = {value_q, key_q};
      end
    end
  end

  // lookup: the highest matching valid slot wins
  always_comb begin
    hit     = 1'b0;
    hit_val = '0;
    for (int s = 0; s < CHAIN_DEPTH; s++) begin
      if ((FILL_W'(s) < fill) &&
          (row_rd[FILL_W + s*ENTRY_W +: ahm_pkg::KEY_W] == key_q)) begin
        hit     = 1'b1;
        hit_val = row_rd[FILL_W + s*ENTRY_W + ahm_pkg::KEY_W +: ahm_pkg::VAL_W];
      end
    end
  end

  // ram write port shared by sweep and insert
  assign we    = cmd_i.sweep | (cmd_i.exec & is_insert & ~full);
  assign waddr = cmd_i.sweep ? sweep_q : bucket_q;
  assign wdata = cmd_i.sweep ? '0 : row_new;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      found_q  <= is_lookup & hit;
      mval_q   <= (is_lookup & hit) ? hit_val : '0;
      status_q <= (is_insert & full) ? ahm_pkg::STATUS_FULL : ahm_pkg::STATUS_DONE;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_value_o = mval_q;
  assign status_o      = status_q;

  // status back to the controller
  assign sts_o.in_kind    = kind_i;
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = ~out_valid_q | out_ready_i;

endmodule

`default_nettype wire

### hw/rtl/ahm_ctrl.sv
// controller: sequences hash, remainder, bucket access, clearing and results
`default_nettype none

module ahm_ctrl #(
  parameter int unsigned NUM_BUCKETS = ahm_pkg::NUM_BUCKETS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ahm_pkg::sts_t sts_i,
  output ahm_pkg::cmd_t cmd_o
);

  localparam int unsigned BW   = $clog2(NUM_BUCKETS);
  localparam bit          POW2 = (NUM_BUCKETS == (1 << BW));

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_MOD   = 7'b0001000,
    S_READ  = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_EXEC  = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.hop  = ahm_pkg::HOP_NONE;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          if (sts_i.in_kind inside {ahm_pkg::KIND_INSERT, ahm_pkg::KIND_LOOKUP}) begin
            state_d = S_HASH;
          end else if (sts_i.in_kind == ahm_pkg::KIND_CLEAR) begin
            state_d = S_CLEAR;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_HASH: begin
        // two multiply rounds then the final xor-shift
        case (cnt_q)
          3'd0, 3'd3: cmd_o.hop = ahm_pkg::HOP_MUL_LO;
          3'd1, 3'd4: cmd_o.hop = ahm_pkg::HOP_MUL_HI;
          3'd2, 3'd5: cmd_o.hop = ahm_pkg::HOP_ADD;
          default:    cmd_o.hop = ahm_pkg::HOP_FIN;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ahm_pkg::HASH_LAST) begin
          cnt_d   = '0;
          state_d = POW2 ? S_READ : S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.hop = ahm_pkg::HOP_MOD;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == ahm_pkg::MOD_LAST) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EXEC;
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ahm_checker.sv
// port-level checker of the address hash map and its bind
`default_nettype none
`include "address_hash_map_defines.svh"

module ahm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      found_i,
  input logic [ahm_pkg::VAL_W-1:0] match_value_i,
  input logic                      status_i
);

  // a stalled result word holds
  `AHM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(found_i) && $stable(match_value_i) && $stable(status_i), "result word changed while stalled")

  // one word at a time: intake closes right after an accept
  `AHM_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "word accepted while another is in flight")

  // a miss reports zero
  `AHM_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, out_valid_i && !found_i, match_value_i == '0, "miss with nonzero match value")

  // a hit is never a dropped insert
  `AHM_ASSERT_IMP(a_hit_done, clk_i, rst_ni, out_valid_i && found_i, status_i == ahm_pkg::STATUS_DONE, "hit flagged as dropped insert")

endmodule

bind address_hash_map ahm_checker u_ahm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .found_i       (out_o.found),
  .match_value_i (out_o.match_value),
  .status_i      (out_o.status)
);

`default_nettype wire

### bench/address_hash_map_test.sv
// self-checking testbench of the address hash map: directed and random words with idling
`default_nettype none

module address_hash_map_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUCKETS   = ahm_pkg::NUM_BUCKETS_DEF;
  localparam int unsigned DEPTH     = ahm_pkg::CHAIN_DEPTH_DEF;
  localparam int unsigned HASH_BITS = ahm_pkg::HASH_W;
  localparam int unsigned RAND_WORDS = 2000;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned MAX_SHOWN  = 10;
  // kind code with no operation behind it
  localparam logic [ahm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [ahm_pkg::KIND_W-1:0] kind;
    logic [ahm_pkg::KEY_W-1:0]  key;
    logic [ahm_pkg::VAL_W-1:0]  value;
  } map_req_t;

  typedef struct packed {
    logic                      found;
    logic [ahm_pkg::VAL_W-1:0] match_value;
    logic                      status;
  } map_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ahm_in_if  in_if ();
  ahm_out_if out_if ();

  address_hash_map #(
    .NUM_BUCKETS (BUCKETS),
    .CHAIN_DEPTH (DEPTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  // mirror of the table contents
  logic [ahm_pkg::KEY_W-1:0] shadow_key   [BUCKETS*DEPTH];
  logic [ahm_pkg::VAL_W-1:0] shadow_value [BUCKETS*DEPTH];
  int unsigned               shadow_fill  [BUCKETS] = '{default: 0};

  map_req_t    request_q [$];
  map_rsp_t    answer_q  [$];
  int unsigned faults = 0;
  logic        in_taken = 1'b0;

  // two rounds of xor-shift-multiply, final xor-shift, then bucket select
  function automatic int unsigned bucket_index(logic [ahm_pkg::KEY_W-1:0] k);
    logic [HASH_BITS-1:0] h;
    h = HASH_BITS'(k);
    for (int r = 0; r < 2; r++) begin
      h = (h ^ (h << ahm_pkg::HASH_SHIFT)) * HASH_BITS'(ahm_pkg::HASH_MULT);
    end
    h = h ^ (h << ahm_pkg::HASH_SHIFT);
    return int'(h % HASH_BITS'(BUCKETS));
  endfunction

  // apply one accepted word to the mirror and work out its result word
  function automatic map_rsp_t map_apply(map_req_t rq);
    map_rsp_t    rs;
    int unsigned b;
    int unsigned n;
    rs = '{found: 1'b0, match_value: '0, status: ahm_pkg::STATUS_DONE};
    b = bucket_index(rq.key);
    n = shadow_fill[b];
    if (rq.kind == ahm_pkg::KIND_INSERT) begin
      if (n >= DEPTH) begin
        rs.status = ahm_pkg::STATUS_FULL;
      end else begin
        shadow_key[b*DEPTH+n]   = rq.key;
        shadow_value[b*DEPTH+n] = rq.value;
        shadow_fill[b]          = n + 1;
      end
    end else if (rq.kind == ahm_pkg::KIND_LOOKUP) begin
      // newest slot first
      for (int s = int'(n) - 1; s >= 0; s--) begin
        if (!rs.found && shadow_key[b*DEPTH+s] == rq.key) begin
          rs.found       = 1'b1;
          rs.match_value = shadow_value[b*DEPTH+s];
        end
      end
    end else if (rq.kind == ahm_pkg::KIND_CLEAR) begin
      foreach (shadow_fill[i]) shadow_fill[i] = 0;
    end
    return rs;
  endfunction

  function automatic logic [ahm_pkg::KEY_W-1:0] rand_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // edge values now and then, otherwise any address
  function automatic logic [ahm_pkg::VAL_W-1:0] rand_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return rand_addr();
    endcase
  endfunction

  function automatic logic [ahm_pkg::KEY_W-1:0] key_in_bucket(int unsigned b);
    logic [ahm_pkg::KEY_W-1:0] k;
    do k = rand_addr(); while (bucket_index(k) != b);
    return k;
  endfunction

  function automatic void push_word(logic [ahm_pkg::KIND_W-1:0] kind,
                                    logic [ahm_pkg::KEY_W-1:0] key,
                                    logic [ahm_pkg::VAL_W-1:0] value);
    request_q.push_back('{kind: kind, key: key, value: value});
  endfunction

  // input side: predict on every accepted word
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      answer_q.push_back(map_apply('{kind: in_if.kind, key: in_if.key, value: in_if.value}));
    end
  end

  // driver: bursts of random length separated by random gaps
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    map_req_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (gap_left != 0 || request_q.size() == 0) begin
        in_if.valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        nxt = request_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.kind  <= nxt.kind;
        in_if.key   <= nxt.key;
        in_if.value <= nxt.value;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(24, 1);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: rotating stall mask, reloaded now and then, sometimes never stalling
  logic [11:0] stall_mask = '1;
  int unsigned mask_age   = 0;

  always @(negedge clk_i) begin
    if (mask_age == 0) begin
      stall_mask = ($urandom_range(3) == 0) ? '1 : (12'($urandom) | 12'h001);
      mask_age   = $urandom_range(500, 200);
    end else begin
      stall_mask = {stall_mask[10:0], stall_mask[11]};
      mask_age--;
    end
    out_if.ready <= stall_mask[0];
  end

  // output side: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    map_rsp_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (answer_q.size() == 0) begin
        faults++;
        if (faults <= MAX_SHOWN) begin
          $display("unexpected result word: found=%0b value=%h status=%0b",
                   out_if.found, out_if.match_value, out_if.status);
        end
      end else begin
        want = answer_q.pop_front();
        if (out_if.found !== want.found || out_if.match_value !== want.match_value ||
            out_if.status !== want.status) begin
          faults++;
          if (faults <= MAX_SHOWN) begin
            $display("result mismatch: expected found=%0b value=%h status=%0b",
                     want.found, want.match_value, want.status);
            $display("                 actual   found=%0b value=%h status=%0b",
                     out_if.found, out_if.match_value, out_if.status);
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("address_hash_map_test: FAIL");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [ahm_pkg::KEY_W-1:0] crowd [5];
    logic [ahm_pkg::KEY_W-1:0] twin;
    logic [ahm_pkg::KEY_W-1:0] pool [$];
    logic [ahm_pkg::KEY_W-1:0] live [$];
    logic [ahm_pkg::KEY_W-1:0] k;
    int unsigned               hot;
    int unsigned               pick;

    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.kind   = ahm_pkg::KIND_INSERT;
    in_if.key    = '0;
    in_if.value  = '0;
    out_if.ready = 1'b0;

    // directed: empty table, extreme keys and values
    push_word(ahm_pkg::KIND_LOOKUP, '0, '0);
    push_word(ahm_pkg::KIND_INSERT, '0, '1);
    push_word(ahm_pkg::KIND_INSERT, '1, '0);
    push_word(ahm_pkg::KIND_LOOKUP, '0, '0);
    push_word(ahm_pkg::KIND_LOOKUP, '1, '0);
    // directed: fill one bucket and overflow it
    hot = $urandom_range(BUCKETS - 1);
    foreach (crowd[i]) crowd[i] = key_in_bucket(hot);
    foreach (crowd[i]) begin
      push_word(ahm_pkg::KIND_INSERT, crowd[i], (i % 2) ? {24{2'b01}} : {24{2'b10}});
    end
    push_word(ahm_pkg::KIND_LOOKUP, crowd[4], '0);
    push_word(ahm_pkg::KIND_LOOKUP, crowd[0], '0);
    push_word(ahm_pkg::KIND_LOOKUP, crowd[3], '0);
    // directed: same key twice, newer value wins
    twin = rand_addr();
    push_word(ahm_pkg::KIND_INSERT, twin, rand_addr());
    push_word(ahm_pkg::KIND_INSERT, twin, rand_addr());
    push_word(ahm_pkg::KIND_LOOKUP, twin, '0);
    // directed: unused kind, then clear and refill
    push_word(KIND_UNUSED, rand_addr(), rand_addr());
    push_word(ahm_pkg::KIND_CLEAR, rand_addr(), rand_addr());
    push_word(ahm_pkg::KIND_LOOKUP, '0, '0);
    push_word(ahm_pkg::KIND_LOOKUP, crowd[3], '0);
    push_word(ahm_pkg::KIND_INSERT, crowd[0], rand_addr());
    push_word(ahm_pkg::KIND_LOOKUP, crowd[0], '0);

    // colliding keys spread over a few buckets so that chains fill up
    for (int b = 0; b < 4; b++) begin
      hot = $urandom_range(BUCKETS - 1);
      for (int j = 0; j < 8; j++) pool.push_back(key_in_bucket(hot));
    end

    // random: mostly inserts and lookups on colliding or live keys
    for (int n = 0; n < RAND_WORDS; n++) begin
      pick = $urandom_range(999);
      if (pick < 12) begin
        push_word(ahm_pkg::KIND_CLEAR, rand_addr(), rand_addr());
        live.delete();
      end else if (pick < 20) begin
        push_word(KIND_UNUSED, rand_addr(), rand_addr());
      end else if (pick < 420) begin
        k = ($urandom_range(9) < 7) ? pool[$urandom_range(pool.size() - 1)] : rand_word();
        push_word(ahm_pkg::KIND_INSERT, k, rand_word());
        live.push_back(k);
        if (live.size() > 48) void'(live.pop_front());
      end else begin
        case ($urandom_range(3))
          0, 1:    k = (live.size() != 0) ? live[$urandom_range(live.size() - 1)] : rand_word();
          2:       k = pool[$urandom_range(pool.size() - 1)];
          default: k = rand_word();
        endcase
        push_word(ahm_pkg::KIND_LOOKUP, k, rand_word());
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain: all words accepted, all results back, then a quiet stretch
    while (request_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (faults == 0) begin
      $display("address_hash_map_test: PASS");
    end else begin
      $display("address_hash_map_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
